[rtl/corexy_step_move_macros.svh]
// ----------------------------------------------------------------------------
// corexy_step_move assertion macros
// shared property forms for the move generator checks
// ----------------------------------------------------------------------------
`ifndef COREXY_STEP_MOVE_MACROS_SVH
`define COREXY_STEP_MOVE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CXY_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("corexy_step_move: implication check failed");

// next-cycle implication, disabled during reset
`define CXY_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("corexy_step_move: next-cycle check failed");

`endif

[rtl/cxy_pkg.sv]
// ----------------------------------------------------------------------------
// cxy_pkg
// shared constants and codes for the corexy move generator
// ----------------------------------------------------------------------------
`default_nettype none

package cxy_pkg;

  localparam int IN_WIDTH          = 24;
  localparam int SPM_WIDTH         = 10;
  localparam int SPM_RESET         = 120;
  localparam int POS_WIDTH_DEF     = 25;
  localparam int FRAC_BITS_DEF     = 8;
  localparam int COUNT_WIDTH_DEF   = 28;

  typedef enum logic {
    CMD_MOVE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

[rtl/corexy_step_move.sv]
// ----------------------------------------------------------------------------
// corexy_step_move
// corexy move generator: move items set a target, tick items step the motors
// ----------------------------------------------------------------------------
// usage:
//   in_*  channel carries items: cmd move (with target_x/target_y, Q.8 mm)
//         or cmd tick. out_* channel returns one result item per input item.
//   cfg_we/cfg_wdata write the steps per mm scale; write only while no item
//   is in flight.
// path: an accepted item goes through the input register, then the result
//   register that also updates the axis state, where its result becomes valid.
// throughput: one item per cycle unless stalled; the step counts come from
//   one multiply by the 10-bit scale per motor, in the single compute stage.
// stall: when out_stall holds a pending result, the compute stage waits and
//   in_stall rises once the input register is also full; nothing is dropped.
// reset: synchronous, active low; position, goal, counts and directions clear,
//   the block is idle and the steps per mm scale returns to 120.
// ----------------------------------------------------------------------------
`default_nettype none

`include "corexy_step_move_macros.svh"

module corexy_step_move #(
  parameter int POS_WIDTH   = cxy_pkg::POS_WIDTH_DEF,
  parameter int FRAC_BITS   = cxy_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = cxy_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_cmd,
  input  wire logic signed [cxy_pkg::IN_WIDTH-1:0]  in_target_x,
  input  wire logic signed [cxy_pkg::IN_WIDTH-1:0]  in_target_y,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_left_step,
  output logic                                      out_left_dir,
  output logic                                      out_right_step,
  output logic                                      out_right_dir,
  output logic                                      out_busy_res,
  output logic                                      out_move_done,
  output logic                                      out_rejected,
  output logic signed [cxy_pkg::IN_WIDTH-1:0]       out_pos_x,
  output logic signed [cxy_pkg::IN_WIDTH-1:0]       out_pos_y,
  input  wire logic                                 cfg_we,
  input  wire logic [cxy_pkg::SPM_WIDTH-1:0]        cfg_wdata
);

  localparam int IW = cxy_pkg::IN_WIDTH;
  localparam int EW = (POS_WIDTH > IW) ? POS_WIDTH : IW;
  localparam int DW = POS_WIDTH + 2;

  // input register
  logic                 in_valid_r;
  cxy_pkg::cmd_t        in_cmd_r;
  logic signed [IW-1:0] in_tx_r, in_ty_r;

  // axis state
  logic [cxy_pkg::SPM_WIDTH-1:0] spm_r;
  logic signed [POS_WIDTH-1:0]   cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic signed [POS_WIDTH-1:0]   cur_x_nxt, cur_y_nxt, goal_x_nxt, goal_y_nxt;
  logic [COUNT_WIDTH-1:0]        left_count_r, right_count_r, iter_count_r;
  logic [COUNT_WIDTH-1:0]        left_count_nxt, right_count_nxt, iter_count_nxt;
  logic [1:0]                    dir_bits_r, dir_bits_nxt;
  logic                          running_r, running_nxt;

  // result register
  logic                 out_valid_r;
  logic                 lstep_r, rstep_r, done_r, rej_r;
  logic                 lstep_nxt, rstep_nxt, done_nxt, rej_nxt;

  logic                 adv, in_take;
  logic signed [POS_WIDTH-1:0] tx, ty;
  logic signed [POS_WIDTH:0]   dx, dy;
  logic signed [DW-1:0]        dist_l, dist_r;
  logic [COUNT_WIDTH-1:0]      lc, rc, longest, iter_inc;
  logic                        ldir, rdir;
  logic signed [EW-1:0]        tx_ext, ty_ext, px_ext, py_ext;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    tx_ext = EW'(in_tx_r);
    ty_ext = EW'(in_ty_r);
    tx     = tx_ext[POS_WIDTH-1:0];
    ty     = ty_ext[POS_WIDTH-1:0];
    dx     = (POS_WIDTH+1)'(tx) - (POS_WIDTH+1)'(cur_x_r);
    dy     = (POS_WIDTH+1)'(ty) - (POS_WIDTH+1)'(cur_y_r);
    dist_l = DW'(dx) + DW'(dy);
    dist_r = DW'(dx) - DW'(dy);
  end

  cxy_steps #(
    .DIST_WIDTH  (DW),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_left (
    .span  (dist_l),
    .spm   (spm_r),
    .count (lc),
    .dir   (ldir)
  );

  cxy_steps #(
    .DIST_WIDTH  (DW),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_right (
    .span  (dist_r),
    .spm   (spm_r),
    .count (rc),
    .dir   (rdir)
  );

  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    goal_x_nxt      = goal_x_r;
    goal_y_nxt      = goal_y_r;
    left_count_nxt  = left_count_r;
    right_count_nxt = right_count_r;
    iter_count_nxt  = iter_count_r;
    dir_bits_nxt    = dir_bits_r;
    running_nxt     = running_r;
    lstep_nxt       = 1'b0;
    rstep_nxt       = 1'b0;
    done_nxt        = 1'b0;
    rej_nxt         = 1'b0;
    longest         = (left_count_r > right_count_r) ? left_count_r : right_count_r;
    iter_inc        = iter_count_r + COUNT_WIDTH'(1);
    unique case (in_cmd_r)
      cxy_pkg::CMD_MOVE: begin
        if (running_r) begin
          rej_nxt = 1'b1;
        end else begin
          left_count_nxt  = lc;
          right_count_nxt = rc;
          dir_bits_nxt    = {rdir, ldir};
          goal_x_nxt      = tx;
          goal_y_nxt      = ty;
          iter_count_nxt  = '0;
          if (lc == '0 && rc == '0) begin
            cur_x_nxt = tx;
            cur_y_nxt = ty;
            done_nxt  = 1'b1;
          end else begin
            running_nxt = 1'b1;
          end
        end
      end
      cxy_pkg::CMD_TICK: begin
        if (running_r) begin
          lstep_nxt      = iter_count_r < left_count_r;
          rstep_nxt      = iter_count_r < right_count_r;
          iter_count_nxt = iter_inc;
          if (iter_inc >= longest || iter_inc == '0) begin
            cur_x_nxt      = goal_x_r;
            cur_y_nxt      = goal_y_r;
            iter_count_nxt = '0;
            running_nxt    = 1'b0;
            done_nxt       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      spm_r         <= cxy_pkg::SPM_WIDTH'(cxy_pkg::SPM_RESET);
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      goal_x_r      <= '0;
      goal_y_r      <= '0;
      left_count_r  <= '0;
      right_count_r <= '0;
      iter_count_r  <= '0;
      dir_bits_r    <= '0;
      running_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        spm_r <= cfg_wdata;
      end
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      if (adv && in_valid_r) begin
        cur_x_r       <= cur_x_nxt;
        cur_y_r       <= cur_y_nxt;
        goal_x_r      <= goal_x_nxt;
        goal_y_r      <= goal_y_nxt;
        left_count_r  <= left_count_nxt;
        right_count_r <= right_count_nxt;
        iter_count_r  <= iter_count_nxt;
        dir_bits_r    <= dir_bits_nxt;
        running_r     <= running_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r <= cxy_pkg::cmd_t'(in_cmd);
      in_tx_r  <= in_target_x;
      in_ty_r  <= in_target_y;
    end
    if (adv && in_valid_r) begin
      lstep_r <= lstep_nxt;
      rstep_r <= rstep_nxt;
      done_r  <= done_nxt;
      rej_r   <= rej_nxt;
    end
  end

  always_comb begin
    px_ext = EW'(cur_x_r);
    py_ext = EW'(cur_y_r);
  end

  assign out_valid      = out_valid_r;
  assign out_left_step  = lstep_r;
  assign out_right_step = rstep_r;
  assign out_left_dir   = dir_bits_r[0];
  assign out_right_dir  = dir_bits_r[1];
  assign out_busy_res   = running_r;
  assign out_move_done  = done_r;
  assign out_rejected   = rej_r;
  assign out_pos_x      = px_ext[IW-1:0];
  assign out_pos_y      = py_ext[IW-1:0];

  // a finished move leaves the block idle
  `CXY_ASSERT_IMP(a_done_idle, clk, rst_n, out_valid_r && done_r, !running_r)
  // a refused move takes no step and only happens while busy
  `CXY_ASSERT_IMP(a_rej_busy, clk, rst_n, out_valid_r && rej_r,
                  running_r && !lstep_r && !rstep_r && !done_r)
  // a running move always has steps to take
  `CXY_ASSERT_IMP(a_run_count, clk, rst_n, running_r,
                  left_count_r != '0 || right_count_r != '0)
  // a held result keeps the axis state frozen
  `CXY_ASSERT_NXT(a_hold_state, clk, rst_n, out_valid_r && out_stall,
                  $stable(running_r) && $stable(iter_count_r) && $stable(cur_x_r))

endmodule

`default_nettype wire

[rtl/cxy_steps.sv]
// ----------------------------------------------------------------------------
// cxy_steps
// scales a signed fixed-point distance by steps per mm, truncates toward
// zero and gives the saturated step count magnitude and its direction
// ----------------------------------------------------------------------------
`default_nettype none

module cxy_steps #(
  parameter int DIST_WIDTH  = cxy_pkg::POS_WIDTH_DEF + 2,
  parameter int FRAC_BITS   = cxy_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = cxy_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic signed [DIST_WIDTH-1:0]      span,
  input  wire logic [cxy_pkg::SPM_WIDTH-1:0]     spm,
  output logic [COUNT_WIDTH-1:0]                 count,
  output logic                                   dir
);

  localparam int PW = DIST_WIDTH + cxy_pkg::SPM_WIDTH + 1;
  localparam int MW = (PW + 1 > COUNT_WIDTH + 1) ? PW + 1 : COUNT_WIDTH + 1;
  localparam logic [PW-1:0] BIAS = PW'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] biased;
  logic signed [PW-1:0] quot;
  logic signed [MW-1:0] quot_ext;
  logic [MW-1:0]        mag;

  always_comb begin
    prod     = PW'(span) * PW'($signed({1'b0, spm}));
    biased   = prod + (prod[PW-1] ? $signed(BIAS) : $signed(PW'(0)));
    quot     = biased >>> FRAC_BITS;
    quot_ext = MW'(quot);
    mag      = quot_ext[MW-1] ? MW'(-quot_ext) : MW'(quot_ext);
    if (|mag[MW-1:COUNT_WIDTH]) begin
      count = '1;
    end else begin
      count = mag[COUNT_WIDTH-1:0];
    end
    dir = !quot[PW-1] && (quot != '0);
  end

endmodule

`default_nettype wire
